FILE: hw/rtl/bel_pkg.sv
// Package for the Boolean expression lexer: token and scan-mode types, the token record,
// character codes and the column arithmetic.
// No dependencies; every RTL file of the lexer imports it.
package bel_pkg;

   localparam int POS_W  = 16;
   localparam int COL_W  = 16;
   localparam int CH_W   = 8;
   localparam int KIND_W = 4;
   localparam int SUM_W  = ((POS_W > COL_W) ? POS_W : COL_W) + 1;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

   localparam logic [CH_W-1:0] CH_NUL        = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CH_W-1:0] CH_BANG       = 8'h21;
   localparam logic [CH_W-1:0] CH_APOSTROPHE = 8'h27;
   localparam logic [CH_W-1:0] CH_LPAREN     = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN     = 8'h29;
   localparam logic [CH_W-1:0] CH_STAR       = 8'h2A;
   localparam logic [CH_W-1:0] CH_PLUS       = 8'h2B;
   localparam logic [CH_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [CH_W-1:0] CH_ONE        = 8'h31;
   localparam logic [CH_W-1:0] CH_NINE       = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [CH_W-1:0] CH_CARET      = 8'h5E;
   localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CH_W-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [CH_W-1:0] CH_AMPERSAND  = 8'h26;
   localparam logic [CH_W-1:0] CH_PIPE       = 8'h7C;

   typedef enum logic [KIND_W-1:0] {
      TK_END    = 4'd0,
      TK_NOT    = 4'd1,
      TK_OR     = 4'd2,
      TK_AND    = 4'd3,
      TK_XOR    = 4'd4,
      TK_LPAREN = 4'd5,
      TK_RPAREN = 4'd6,
      TK_PRIME  = 4'd7,
      TK_SYMBOL = 4'd8,
      TK_NUMBER = 4'd9,
      TK_ERROR  = 4'd10
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } scan_mode_type;

   typedef struct packed {
      token_kind_type   kind;
      logic [COL_W-1:0] first_column;
      logic [COL_W-1:0] last_column;
      logic             is_last;
   } token_type;

   // Tokens produced by one character, handed from the scanner to the queue.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic [COL_W-1:0] column_of(input logic [COL_W-1:0] base,
                                                  input logic [POS_W-1:0] idx);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(idx) + SUM_W'(1);
      if (sum > SUM_W'(COL_MAX)) begin
         return COL_MAX;
      end
      return sum[COL_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bel_scan.sv
// Scanner of the Boolean expression lexer: input character register, scan state and
// classification of one character into up to two tokens.
// Depends on bel_pkg.
module bel_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [bel_pkg::CH_W-1:0]  req_ch,
   output logic                      req_stall,
   input  logic [bel_pkg::COL_W-1:0] base_column,
   input  logic                      room,
   output bel_pkg::push_type         push
);
   import bel_pkg::*;

   logic [CH_W-1:0]  ch_ff;
   logic             ch_valid_ff, ch_valid_in;
   scan_mode_type    mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;

   logic             process;
   logic             is_alpha, is_digit, is_word, is_bin, is_blank;
   logic             cont, run_end, single;
   token_kind_type   run_kind, single_kind;
   logic [POS_W-1:0] prev_pos, pos_adv;
   logic [COL_W-1:0] col_start, col_prev, col_pos;
   token_type        run_tok, single_tok;

   // The held character is worked on once the queue has room for two tokens.
   assign process     = ch_valid_ff && room;
   assign req_stall   = ch_valid_ff && !process;
   assign ch_valid_in = req_valid ? 1'b1 : (ch_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         ch_ff <= req_ch;
      end
      if (reset) begin
         ch_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         start_ff    <= '0;
      end else begin
         ch_valid_ff <= ch_valid_in;
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
      end
   end

   assign is_alpha = ((ch_ff >= CH_LOWER_A) && (ch_ff <= CH_LOWER_Z)) ||
                     ((ch_ff >= CH_UPPER_A) && (ch_ff <= CH_UPPER_Z)) ||
                     (ch_ff == CH_UNDERSCORE);
   assign is_digit = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
   assign is_word  = is_alpha || is_digit;
   assign is_bin   = (ch_ff == CH_ZERO) || (ch_ff == CH_ONE);
   assign is_blank = (ch_ff == CH_SPACE) || (ch_ff == CH_TAB);

   assign prev_pos = (pos_ff == '0) ? '0 : pos_ff - POS_W'(1);
   assign pos_adv  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);

   assign col_start = column_of(base_column, start_ff);
   assign col_prev  = column_of(base_column, prev_pos);
   assign col_pos   = column_of(base_column, pos_ff);

   always_comb begin
      case (ch_ff)
         CH_NUL:        single_kind = TK_END;
         CH_BANG:       single_kind = TK_NOT;
         CH_PIPE:       single_kind = TK_OR;
         CH_PLUS:       single_kind = TK_OR;
         CH_AMPERSAND:  single_kind = TK_AND;
         CH_STAR:       single_kind = TK_AND;
         CH_CARET:      single_kind = TK_XOR;
         CH_LPAREN:     single_kind = TK_LPAREN;
         CH_RPAREN:     single_kind = TK_RPAREN;
         CH_APOSTROPHE: single_kind = TK_PRIME;
         default:       single_kind = TK_ERROR;
      endcase
   end

   always_comb begin
      cont     = 1'b0;
      run_end  = 1'b0;
      run_kind = TK_SYMBOL;
      case (mode_ff)
         MODE_IDENT: begin
            if (is_word) begin
               cont = 1'b1;
            end else begin
               run_end = 1'b1;
            end
         end
         MODE_NUMBER: begin
            run_kind = TK_NUMBER;
            if (is_bin) begin
               cont = 1'b1;
            end else begin
               run_end = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign single = !cont && !is_alpha && !is_bin && !is_blank;

   assign run_tok    = '{kind: run_kind, first_column: col_start, last_column: col_prev,
                         is_last: !single};
   assign single_tok = '{kind: single_kind, first_column: col_pos, last_column: col_pos,
                         is_last: 1'b1};

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      push     = '0;
      if (process) begin
         if (cont) begin
            pos_in = pos_adv;
         end else begin
            mode_in = MODE_IDLE;
            if (is_alpha) begin
               mode_in  = MODE_IDENT;
               start_in = pos_ff;
               pos_in   = pos_adv;
            end else if (is_bin) begin
               mode_in  = MODE_NUMBER;
               start_in = pos_ff;
               pos_in   = pos_adv;
            end else if (is_blank) begin
               pos_in = pos_adv;
            end else if (single_kind == TK_END) begin
               pos_in   = '0;
               start_in = '0;
            end else begin
               start_in = pos_ff;
               pos_in   = pos_adv;
            end

            // A finished run goes out ahead of the token of the character that ended it.
            if (run_end && single) begin
               push.count = 2'd2;
               push.tok0  = run_tok;
               push.tok1  = single_tok;
            end else if (run_end) begin
               push.count = 2'd1;
               push.tok0  = run_tok;
            end else if (single) begin
               push.count = 2'd1;
               push.tok0  = single_tok;
            end
         end
      end
   end

endmodule

FILE: hw/rtl/bel_queue.sv
// Token queue of the Boolean expression lexer: four result registers that take up to two
// tokens a cycle and hand one a cycle to the response channel while rsp_stall is low.
// Depends on bel_pkg.
module bel_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  bel_pkg::push_type         push,
   output logic                      room,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bel_pkg::token_type        rsp_token
);
   import bel_pkg::*;

   token_type  entry_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_token = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign head_in  = pop ? head_ff + 2'd1 : head_ff;
   assign tail_in  = tail_ff + push.count;
   assign count_in = count_ff + 3'(push.count) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + 2'd1] <= push.tok1;
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/boolean_expression_lexer.sv
// Top level of the Boolean expression lexer: base column register, scanner and token queue.
// Depends on bel_pkg, bel_scan and bel_queue.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_ch
//   rsp      out        rsp_valid/stall    rsp_token_kind, rsp_first_column,
//                                          rsp_last_column, rsp_is_last
//   csr      in         csr_valid/ready    csr_base_column
//
// One character is taken per cycle while req_stall is low; a character that closes a run
// and is itself a token gives two tokens, which leave the queue one at a time, so the
// output sets the pace. A request waits in the input register before it reaches the queue.
// Synchronous reset clears the scan state, the position counters and the queue.
// The queue holds up to four tokens and stalls requests once more than two are waiting.
module boolean_expression_lexer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bel_pkg::CH_W-1:0]   req_ch,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bel_pkg::KIND_W-1:0] rsp_token_kind,
   output logic [bel_pkg::COL_W-1:0]  rsp_first_column,
   output logic [bel_pkg::COL_W-1:0]  rsp_last_column,
   output logic                       rsp_is_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bel_pkg::COL_W-1:0]  csr_base_column
);
   import bel_pkg::*;

   logic [COL_W-1:0] base_column_ff;
   logic             room;
   push_type         push;
   token_type        rsp_token;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_column_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_column_ff <= csr_base_column;
      end
   end

   bel_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ch      (req_ch),
      .req_stall   (req_stall),
      .base_column (base_column_ff),
      .room        (room),
      .push        (push)
   );

   bel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_token (rsp_token)
   );

   assign rsp_token_kind   = rsp_token.kind;
   assign rsp_first_column = rsp_token.first_column;
   assign rsp_last_column  = rsp_token.last_column;
   assign rsp_is_last      = rsp_token.is_last;

endmodule
